/* sv/sorted_table_nearest_value_search_defines.svh */
// Assertion macros shared by the sorted table search RTL.
`ifndef SORTED_TABLE_NEAREST_VALUE_SEARCH_DEFINES_SVH
`define SORTED_TABLE_NEAREST_VALUE_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
`define STNV_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define STNV_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define STNV_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define STNV_ASSERT_ALWAYS(name, expr, msg)
`define STNV_ASSERT_IMPL(name, pre, post, msg)
`define STNV_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

/* sv/stnv_pkg.sv */
// Types and constants of the sorted table nearest value search block.
package stnv_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int VALUE_W     = 30;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int TDATA_W     = ((VALUE_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_Q_LOWER,
        ST_Q_UPPER,
        ST_SH_RD,
        ST_SH_WR,
        ST_INSERT,
        ST_RESULT
    } state_t;

endpackage

/* sv/stnv_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module stnv_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 30
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/sorted_table_nearest_value_search.sv */
// Top level of the sorted table with nearest value search.
//
// Requests arrive on the s_ channel: s_tuser carries the request kind (load, query or
// clear) and s_tdata the value. Every request yields exactly one result on the m_
// channel: m_tdata carries the nearest stored value and m_tuser the status.
// A load binary-searches for the insertion point, moves the larger entries up one slot
// at one entry per cycle and then writes the value. Each search step is a read of the
// table memory followed by a compare, through its single read port. One request is in
// work at a time; s_tready is high only while the sequencer is idle.
// Reset empties the table by clearing the fill count; the memory itself is not swept.
// A result waits in the output register while the receiver stalls, and the block still
// takes the next request, but that request's result waits until the register is free.
`include "sorted_table_nearest_value_search_defines.svh"

module sorted_table_nearest_value_search (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [stnv_pkg::TDATA_W-1:0] s_tdata,  // value
    input  logic [stnv_pkg::REQ_W-1:0]   s_tuser,  // req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [stnv_pkg::TDATA_W-1:0] m_tdata,  // nearest
    output logic [stnv_pkg::STATUS_W-1:0] m_tuser  // status
);
    import stnv_pkg::*;

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    req_t                 s_req;
    logic [VALUE_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     sh_reg, sh_next;
    logic [VALUE_W-1:0]   lower_reg, lower_next;
    logic [VALUE_W-1:0]   dlo_reg, dlo_next;
    logic [VALUE_W-1:0]   res_nearest_reg, res_nearest_next;
    status_t              res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]   m_nearest_reg, m_nearest_next;
    status_t              m_status_reg, m_status_next;

    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid;
    logic [CNT_W-1:0]     lo_m1;
    logic [CNT_W-1:0]     sh_m1;
    logic [CNT_W-1:0]     sh_m2;
    logic [VALUE_W-1:0]   dup;
    logic                 below;

    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [VALUE_W-1:0]   rd_data;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [VALUE_W-1:0]   wr_data;

    logic                 full_load_acc;
    logic                 full_drop_held;

    stnv_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_req   = req_t'(s_tuser);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign lo_m1   = lo_reg - 1'b1;
    assign sh_m1   = sh_reg - 1'b1;
    assign sh_m2   = sh_reg - 2'd2;
    assign dup     = rd_data - key_reg;
    assign below   = (req_reg == REQ_LOAD) ? (rd_data <= key_reg) : (rd_data < key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        key_reg         <= key_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        sh_reg          <= sh_next;
        lower_reg       <= lower_next;
        dlo_reg         <= dlo_next;
        res_nearest_reg <= res_nearest_next;
        res_status_reg  <= res_status_next;
        m_nearest_reg   <= m_nearest_next;
        m_status_reg    <= m_status_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        key_next         = key_reg;
        count_next       = count_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        sh_next          = sh_reg;
        lower_next       = lower_reg;
        dlo_next         = dlo_reg;
        res_nearest_next = res_nearest_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_nearest_next   = m_nearest_reg;
        m_status_next    = m_status_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = key_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next         = s_req;
                    key_next         = s_tdata[VALUE_W-1:0];
                    res_nearest_next = '0;
                    res_status_next  = STAT_OK;
                    lo_next          = '0;
                    hi_next          = count_reg;
                    state_next       = ST_RESULT;
                    unique case (s_req)
                        REQ_LOAD:
                        begin
                            if (count_reg == DEPTH_CNT)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid[ADDR_W-1:0];
                    state_next = ST_COMPARE;
                end
                else if (req_reg == REQ_LOAD)
                begin
                    if (count_reg > lo_reg)
                    begin
                        sh_next    = count_reg;
                        state_next = ST_SH_RD;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = (lo_reg == '0) ? '0 : lo_m1[ADDR_W-1:0];
                    state_next = ST_Q_LOWER;
                end
            end
            ST_COMPARE:
            begin
                if (below)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_SEARCH;
            end
            ST_Q_LOWER:
            begin
                lower_next = rd_data;
                if (lo_reg == '0 || lo_reg == count_reg)
                begin
                    res_nearest_next = rd_data;
                    state_next       = ST_RESULT;
                end
                else
                begin
                    dlo_next   = key_reg - rd_data;
                    rd_en      = 1'b1;
                    rd_addr    = lo_reg[ADDR_W-1:0];
                    state_next = ST_Q_UPPER;
                end
            end
            ST_Q_UPPER:
            begin
                res_nearest_next = (dlo_reg <= dup) ? lower_reg : rd_data;
                state_next       = ST_RESULT;
            end
            ST_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = sh_m1[ADDR_W-1:0];
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = sh_reg[ADDR_W-1:0];
                wr_data = rd_data;
                sh_next = sh_m1;
                if (sh_m1 > lo_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = sh_m2[ADDR_W-1:0];
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[ADDR_W-1:0];
                wr_data    = key_reg;
                count_next = count_reg + 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next   = 1'b1;
                    m_nearest_next = res_nearest_reg;
                    m_status_next  = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - VALUE_W){1'b0}}, m_nearest_reg};
    assign m_tuser  = m_status_reg;

    assign full_load_acc  = s_tvalid && s_tready && s_req == REQ_LOAD && count_reg == DEPTH_CNT;
    assign full_drop_held = state_reg == ST_RESULT && res_status_reg == STAT_FULL
                            && count_reg == DEPTH_CNT;

    `STNV_ASSERT_ALWAYS(a_count_range, count_reg <= DEPTH_CNT, "fill count above table depth")
    `STNV_ASSERT_IMPL(a_search_bounds, state_reg == ST_COMPARE, lo_reg < hi_reg, "empty window")
    `STNV_ASSERT_IMPL(a_shift_above_slot, state_reg == ST_SH_WR, sh_reg > lo_reg, "shift too low")
    `STNV_ASSERT_NEXT(a_full_drop, full_load_acc, full_drop_held, "full table load not dropped")

endmodule

/* tb/sv/stnv_result_checker.sv */
// Checker that predicts and compares the results of the sorted table search block.
`timescale 1ns / 100ps

module stnv_result_checker
    import stnv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,  // value
    input  logic [REQ_W-1:0]    s_tuser,  // req_type
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [TDATA_W-1:0]  m_tdata,  // nearest
    input  logic [STATUS_W-1:0] m_tuser,  // status
    output int                  mismatches,
    output int                  outstanding
);

    typedef struct packed {
        logic [VALUE_W-1:0] nearest;
        status_t            status;
    } answer_t;

    answer_t            answers_due[$];
    logic [VALUE_W-1:0] shadow_table [TABLE_DEPTH];
    int unsigned        shadow_count;
    int                 mismatch_total;
    int                 result_seq;

    task automatic report_mismatch(input string line);
        $display("MISMATCH at %0t, result %0d: %s", $realtime, result_seq, line);
        mismatch_total++;
    endtask

    // Updates the shadow table for one request and returns the answer it must produce.
    function automatic answer_t apply_request(input logic [REQ_W-1:0] kind,
                                              input logic [VALUE_W-1:0] val);
        answer_t            ans;
        int unsigned        pos;
        int unsigned        idx;
        logic [VALUE_W-1:0] lower;
        logic [VALUE_W-1:0] upper;
        ans.nearest = '0;
        ans.status  = STAT_OK;
        case (kind)
            REQ_LOAD:
            begin
                if (shadow_count >= TABLE_DEPTH)
                begin
                    ans.status = STAT_FULL;
                end
                else
                begin
                    // A new value lands after any equal entries already stored.
                    pos = 0;
                    while (pos < shadow_count && shadow_table[pos] <= val)
                        pos++;
                    for (idx = shadow_count; idx > pos; idx--)
                        shadow_table[idx] = shadow_table[idx-1];
                    shadow_table[pos] = val;
                    shadow_count++;
                end
            end
            REQ_QUERY:
            begin
                if (shadow_count == 0)
                begin
                    ans.status = STAT_EMPTY;
                end
                else
                begin
                    pos = 0;
                    while (pos < shadow_count && shadow_table[pos] < val)
                        pos++;
                    if (pos == 0)
                        ans.nearest = shadow_table[0];
                    else if (pos == shadow_count)
                        ans.nearest = shadow_table[shadow_count-1];
                    else
                    begin
                        lower = shadow_table[pos-1];
                        upper = shadow_table[pos];
                        ans.nearest = (val - lower <= upper - val) ? lower : upper;
                    end
                end
            end
            REQ_CLEAR:
            begin
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t ans;
        if (!rst_n)
        begin
            shadow_count = 0;
            answers_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result nearest=%0h status=%0d",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    ans = answers_due.pop_front();
                    if (m_tdata !== TDATA_W'(ans.nearest))
                        report_mismatch($sformatf("nearest expected %0h, got %0h",
                                                  ans.nearest, m_tdata));
                    if (m_tuser !== ans.status)
                        report_mismatch($sformatf("status expected %0d, got %0d",
                                                  ans.status, m_tuser));
                end
                result_seq++;
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(apply_request(s_tuser, s_tdata[VALUE_W-1:0]));
            mismatches  <= mismatch_total;
            outstanding <= answers_due.size();
        end
    end

endmodule

/* tb/sv/tb_sorted_table_nearest_value_search.sv */
// Testbench top that drives requests into the sorted table search block and gives the verdict.
`timescale 1ns / 100ps

module tb_sorted_table_nearest_value_search;
    import stnv_pkg::*;

    localparam logic [REQ_W-1:0]   REQ_UNUSED      = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MAX       = '1;
    localparam int                 RANDOM_ITEMS    = 160;
    localparam int                 CALM_ITEMS      = 40;
    localparam int                 SMALL_TABLE_CAP = 96;
    localparam int                 FULL_PREFILL    = TABLE_DEPTH - 4;

    typedef enum int {VS_FULL, VS_LOW, VS_HIGH, VS_EDGE} value_style_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    int                 mismatches;
    int                 outstanding;
    int                 sender_idle_pct   = 20;
    int                 receiver_idle_pct = 20;
    int                 stall_left        = 0;
    bit                 calm              = 1'b0;
    int                 fill_level        = 0;
    int                 random_sent       = 0;
    logic [VALUE_W-1:0] loaded_values[$];

    sorted_table_nearest_value_search i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    stnv_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < receiver_idle_pct)
        begin
            stall_left = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic logic [VALUE_W-1:0] pick_value(input value_style_t style);
        case (style)
            VS_LOW:  return VALUE_W'($urandom_range(0, 63));
            VS_HIGH: return VALUE_MAX - VALUE_W'($urandom_range(0, 63));
            VS_EDGE: return $urandom_range(0, 1) ? VALUE_MAX : '0;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Query values cluster around stored values so that exact hits and ties come up often.
    function automatic logic [VALUE_W-1:0] pick_query();
        logic [VALUE_W:0] a;
        logic [VALUE_W:0] b;
        int unsigned      delta;
        if (loaded_values.size() == 0 || $urandom_range(0, 4) == 0)
            return pick_value(value_style_t'($urandom_range(0, 3)));
        a = {1'b0, loaded_values[$urandom_range(0, loaded_values.size() - 1)]};
        b = {1'b0, loaded_values[$urandom_range(0, loaded_values.size() - 1)]};
        delta = $urandom_range(0, 8);
        case ($urandom_range(0, 3))
            0: return VALUE_W'(a);
            1: return (a + delta > VALUE_MAX) ? VALUE_MAX : VALUE_W'(a + delta);
            2: return (a < delta) ? '0 : VALUE_W'(a - delta);
            default: return VALUE_W'((a + b) >> 1);
        endcase
    endfunction

    task automatic issue(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] val);
        int gap;
        if (!calm && $urandom_range(0, 99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= TDATA_W'(val);
        do @(posedge clk); while (!s_tready);
        if (kind == REQ_LOAD && fill_level < TABLE_DEPTH)
        begin
            fill_level++;
            loaded_values.push_back(val);
        end
        else if (kind == REQ_CLEAR)
        begin
            fill_level = 0;
            loaded_values.delete();
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        #40_000_000;
        $display("** sorted_table_nearest_value_search: FAILED **");
        $finish;
    end

    initial
    begin
        logic [VALUE_W:0]   prev;
        int                 phase_len;
        int                 load_pct;
        int                 roll;
        value_style_t       style;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        issue(REQ_QUERY, VALUE_MAX);
        issue(REQ_UNUSED, 30'h2AAA_AAAA);
        issue(REQ_CLEAR, 30'h1555_5555);
        issue(REQ_LOAD, 30'd1000);
        issue(REQ_LOAD, '0);
        issue(REQ_LOAD, VALUE_MAX);
        issue(REQ_LOAD, 30'd1000);
        issue(REQ_LOAD, 30'd500);
        issue(REQ_QUERY, '0);
        issue(REQ_QUERY, VALUE_MAX);
        issue(REQ_QUERY, 30'd250);
        issue(REQ_QUERY, 30'd251);
        issue(REQ_QUERY, 30'd750);
        issue(REQ_QUERY, 30'd1000);
        issue(REQ_QUERY, 30'h2AAA_AAAA);
        issue(REQ_QUERY, 30'h1555_5555);
        issue(REQ_QUERY, VALUE_MAX - 30'd1);
        issue(REQ_UNUSED, VALUE_MAX);
        issue(REQ_CLEAR, '0);
        issue(REQ_QUERY, 30'd7);
        issue(REQ_LOAD, 30'd7);
        issue(REQ_QUERY, '0);
        issue(REQ_QUERY, VALUE_MAX);
        drain();

        // Fill the table with ascending values so the loads stay short, then push it
        // to full with loads of zero, the maximum and random values; the zero load moves every entry.
        issue(REQ_CLEAR, '0);
        prev = (VALUE_W+1)'($urandom_range(1, 1000));
        repeat (FULL_PREFILL)
        begin
            if ($urandom_range(0, 7) != 0)
                prev = prev + (VALUE_W+1)'($urandom_range(1, 1_000_000));
            issue(REQ_LOAD, VALUE_W'(prev));
        end
        issue(REQ_LOAD, '0);
        issue(REQ_LOAD, VALUE_MAX);
        issue(REQ_LOAD, pick_value(VS_FULL));
        issue(REQ_LOAD, pick_value(VS_FULL));
        repeat (3) issue(REQ_LOAD, pick_value(VS_FULL));
        repeat (24) issue(REQ_QUERY, pick_query());
        issue(REQ_QUERY, '0);
        issue(REQ_QUERY, VALUE_MAX);
        issue(REQ_CLEAR, '0);
        issue(REQ_QUERY, pick_value(VS_FULL));

        while (random_sent < RANDOM_ITEMS)
        begin
            calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
            sender_idle_pct   = 10 * $urandom_range(0, 3);
            receiver_idle_pct = 10 * $urandom_range(0, 3);
            if (!calm && $urandom_range(0, 5) == 0)
                drain();
            style     = value_style_t'($urandom_range(0, 3));
            phase_len = $urandom_range(10, 60);
            load_pct  = $urandom_range(20, 70);
            repeat (phase_len)
            begin
                roll = $urandom_range(0, 99);
                if (fill_level >= SMALL_TABLE_CAP || roll < 2)
                    issue(REQ_CLEAR, pick_value(VS_FULL));
                else if (roll < 4)
                    issue(REQ_UNUSED, pick_value(VS_FULL));
                else if (roll < 4 + load_pct)
                    issue(REQ_LOAD, pick_value($urandom_range(0, 3) == 0 ? VS_FULL : style));
                else
                    issue(REQ_QUERY, pick_query());
                if (roll >= 2 && roll < 4 && fill_level < SMALL_TABLE_CAP)
                    continue;
                random_sent++;
            end
        end

        calm = 1'b1;
        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("** sorted_table_nearest_value_search: PASSED **");
        else
            $display("** sorted_table_nearest_value_search: FAILED **");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/stnv_pkg.sv
sv/stnv_ram.sv
sv/sorted_table_nearest_value_search.sv
tb/sv/stnv_result_checker.sv
tb/sv/tb_sorted_table_nearest_value_search.sv
